// ===== rtl/ssc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

  // Default coordinate width, micrometres, signed
  localparam int CoordBitsDef = 24;

endpackage

`default_nettype wire

// ===== rtl/segment_slab_clip.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Beat
// in        sink       in_valid_i / in_stall_o  func, segment endpoints, slab bounds
// out       source     out_valid_o / out_stall_i hit, clipped endpoints
//
// One beat enters per cycle and one result leaves per cycle, sustained while the output is not stalled.
// The pipeline holds three prep stages
// (differences, magnitudes and decisions, products), one stage per quotient
// bit in the restoring dividers, and the output register.
// A stalled output freezes the whole pipeline; in_stall_o follows at once.
// Reset clears all valid bits; payload registers are not reset.
module segment_slab_clip #(
  parameter int COORD_BITS = ssc_pkg::CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  func_i,
  input  wire logic [COORD_BITS-1:0] seg_start_x_i,
  input  wire logic [COORD_BITS-1:0] seg_start_y_i,
  input  wire logic [COORD_BITS-1:0] seg_start_z_i,
  input  wire logic [COORD_BITS-1:0] seg_end_x_i,
  input  wire logic [COORD_BITS-1:0] seg_end_y_i,
  input  wire logic [COORD_BITS-1:0] seg_end_z_i,
  input  wire logic [COORD_BITS-1:0] slab_low_i,
  input  wire logic [COORD_BITS-1:0] slab_high_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       hit_o,
  output logic      [COORD_BITS-1:0] clip_start_x_o,
  output logic      [COORD_BITS-1:0] clip_start_y_o,
  output logic      [COORD_BITS-1:0] clip_start_z_o,
  output logic      [COORD_BITS-1:0] clip_end_x_o,
  output logic      [COORD_BITS-1:0] clip_end_y_o,
  output logic      [COORD_BITS-1:0] clip_end_z_o
);

  localparam int W  = COORD_BITS;
  localparam int QB = COORD_BITS + 1;

  typedef struct packed {
    logic                hit;
    logic                ulo;
    logic                uhi;
    logic                ax;
    logic [2:0][W-1:0]   p1;
    logic [2:0][W-1:0]   p2;
    logic [W-1:0]        lo;
    logic [W-1:0]        hi;
    logic [W-1:0]        so0;
    logic [W-1:0]        so1;
    logic [3:0]          neg;
  } ctl_t;

  function automatic logic [QB-1:0] mag(input logic signed [QB-1:0] v);
    logic signed [QB-1:0] n;
    n = -v;
    return v[QB-1] ? n : v;
  endfunction

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---- Stage A: differences ----
  logic                 a_v_q;
  logic                 a_ax_q;
  logic [2:0][W-1:0]    a_s_q;
  logic [2:0][W-1:0]    a_e_q;
  logic [W-1:0]         a_lo_q, a_hi_q;
  logic [2:0][QB-1:0]   a_d_q;
  logic [QB-1:0]        a_nlo_q, a_nhi_q;
  logic signed [W-1:0]  in_sax;

  assign in_sax = func_i ? seg_start_y_i : seg_start_x_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q  <= func_i;
      a_s_q   <= {seg_start_z_i, seg_start_y_i, seg_start_x_i};
      a_e_q   <= {seg_end_z_i, seg_end_y_i, seg_end_x_i};
      a_lo_q  <= slab_low_i;
      a_hi_q  <= slab_high_i;
      a_d_q[0] <= {seg_end_x_i[W-1], seg_end_x_i} - {seg_start_x_i[W-1], seg_start_x_i};
      a_d_q[1] <= {seg_end_y_i[W-1], seg_end_y_i} - {seg_start_y_i[W-1], seg_start_y_i};
      a_d_q[2] <= {seg_end_z_i[W-1], seg_end_z_i} - {seg_start_z_i[W-1], seg_start_z_i};
      a_nlo_q <= {slab_low_i[W-1], slab_low_i} - {in_sax[W-1], in_sax};
      a_nhi_q <= {slab_high_i[W-1], slab_high_i} - {in_sax[W-1], in_sax};
    end
  end

  // ---- Stage B: magnitudes, signs and clip decisions ----
  logic signed [QB-1:0] dax, do0, do1;
  logic signed [W-1:0]  sax, eax, p1ax, p2ax, lo_s, hi_s;
  logic                 fwd, nz;
  ctl_t                 b_ctl_d, b_ctl_q;
  logic                 b_v_q;
  logic [QB-1:0]        b_mlo_q, b_mhi_q, b_mdax_q, b_mdo0_q, b_mdo1_q;

  assign dax  = a_ax_q ? a_d_q[1] : a_d_q[0];
  assign do0  = a_ax_q ? a_d_q[0] : a_d_q[1];
  assign do1  = a_d_q[2];
  assign sax  = a_ax_q ? a_s_q[1] : a_s_q[0];
  assign eax  = a_ax_q ? a_e_q[1] : a_e_q[0];
  assign lo_s = a_lo_q;
  assign hi_s = a_hi_q;
  assign fwd  = !dax[QB-1];
  assign nz   = (dax != '0);
  assign p1ax = fwd ? sax : eax;
  assign p2ax = fwd ? eax : sax;

  always_comb begin
    b_ctl_d.hit = nz ? ((p1ax <= hi_s) && (p2ax >= lo_s)) : ((sax >= lo_s) && (sax <= hi_s));
    b_ctl_d.ulo = nz && (p1ax < lo_s);
    b_ctl_d.uhi = nz && (p2ax > hi_s);
    b_ctl_d.ax  = a_ax_q;
    b_ctl_d.p1  = fwd ? a_s_q : a_e_q;
    b_ctl_d.p2  = fwd ? a_e_q : a_s_q;
    b_ctl_d.lo  = a_lo_q;
    b_ctl_d.hi  = a_hi_q;
    b_ctl_d.so0 = a_ax_q ? a_s_q[0] : a_s_q[1];
    b_ctl_d.so1 = a_s_q[2];
    b_ctl_d.neg[0] = a_nlo_q[QB-1] ^ do0[QB-1] ^ dax[QB-1];
    b_ctl_d.neg[1] = a_nlo_q[QB-1] ^ do1[QB-1] ^ dax[QB-1];
    b_ctl_d.neg[2] = a_nhi_q[QB-1] ^ do0[QB-1] ^ dax[QB-1];
    b_ctl_d.neg[3] = a_nhi_q[QB-1] ^ do1[QB-1] ^ dax[QB-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_ctl_q  <= b_ctl_d;
      b_mlo_q  <= mag(a_nlo_q);
      b_mhi_q  <= mag(a_nhi_q);
      b_mdax_q <= mag(dax);
      b_mdo0_q <= mag(do0);
      b_mdo1_q <= mag(do1);
    end
  end

  // ---- Stage C: products ----
  logic                  c_v_q;
  ctl_t                  c_ctl_q;
  logic [3:0][2*QB-1:0]  c_prod_q;
  logic [QB-1:0]         c_mdax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_ctl_q     <= b_ctl_q;
      c_mdax_q    <= b_mdax_q;
      c_prod_q[0] <= b_mlo_q * b_mdo0_q;
      c_prod_q[1] <= b_mlo_q * b_mdo1_q;
      c_prod_q[2] <= b_mhi_q * b_mdo0_q;
      c_prod_q[3] <= b_mhi_q * b_mdo1_q;
    end
  end

  // ---- Dividers, with control carried alongside ----
  logic [3:0][QB-1:0] quo;

  for (genvar j = 0; j < 4; j++) begin : g_div
    ssc_div #(.QB(QB)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .dvd_i (c_prod_q[j]),
      .dvs_i (c_mdax_q),
      .quo_o (quo[j])
    );
  end

  ctl_t line_q [QB];
  logic [QB-1:0] line_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_v_q <= '0;
    end else if (en) begin
      line_v_q <= {line_v_q[QB-2:0], c_v_q};
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_line
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          line_q[k] <= c_ctl_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          line_q[k] <= line_q[k-1];
        end
      end
    end
  end

  // ---- Output stage: sign, offset, assemble ----
  ctl_t                 f;
  logic [3:0][W-1:0]    oc;
  logic [2:0][W-1:0]    pa, pb;

  assign f = line_q[QB-1];

  for (genvar j = 0; j < 4; j++) begin : g_fin
    logic signed [QB:0] qs;
    logic signed [QB:0] sum;
    logic [W-1:0]       so;
    assign so  = (j == 1 || j == 3) ? f.so1 : f.so0;
    assign qs  = f.neg[j] ? -$signed({1'b0, quo[j]}) : $signed({1'b0, quo[j]});
    assign sum = $signed({{2{so[W-1]}}, so}) + qs;
    assign oc[j] = sum[W-1:0];
  end

  always_comb begin
    pa = f.p1;
    pb = f.p2;
    if (f.ulo) begin
      pa = f.ax ? {oc[1], f.lo, oc[0]} : {oc[1], oc[0], f.lo};
    end
    if (f.uhi) begin
      pb = f.ax ? {oc[3], f.hi, oc[2]} : {oc[3], oc[2], f.hi};
    end
    if (!f.hit) begin
      pa = '0;
      pb = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= line_v_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o          <= f.hit;
      clip_start_x_o <= pa[0];
      clip_start_y_o <= pa[1];
      clip_start_z_o <= pa[2];
      clip_end_x_o   <= pb[0];
      clip_end_y_o   <= pb[1];
      clip_end_z_o   <= pb[2];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ssc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage, QB stages deep.
// The dividend's upper half must be below the divisor for a meaningful result.
module ssc_div #(
  parameter int QB = ssc_pkg::CoordBitsDef + 1
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [2*QB-1:0] dvd_i,
  input  wire logic [QB-1:0]   dvs_i,
  output logic      [QB-1:0]   quo_o
);

  logic [QB-1:0] rem_q [QB];
  logic [QB-1:0] low_q [QB];
  logic [QB-1:0] dvs_q [QB];
  logic [QB-1:0] quo_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_st
    logic [QB-1:0] r_in;
    logic [QB-1:0] l_in;
    logic [QB-1:0] d_in;
    logic [QB-1:0] q_in;
    logic [QB:0]   r_sh;
    logic [QB:0]   r_sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = dvd_i[2*QB-1:QB];
      assign l_in = dvd_i[QB-1:0];
      assign d_in = dvs_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign l_in = low_q[k-1];
      assign d_in = dvs_q[k-1];
      assign q_in = quo_q[k-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    assign r_sh  = {r_in, l_in[QB-1]};
    assign ge    = (r_sh >= {1'b0, d_in});
    assign r_sub = r_sh - {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? r_sub[QB-1:0] : r_sh[QB-1:0];
        low_q[k] <= {l_in[QB-2:0], 1'b0};
        dvs_q[k] <= d_in;
        quo_q[k] <= {q_in[QB-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

`default_nettype wire

// ===== rtl/ssc_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssc_chk #(
  parameter int COORD_BITS = ssc_pkg::CoordBitsDef
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic                  hit_o,
  input wire logic [COORD_BITS-1:0] clip_start_x_o,
  input wire logic [COORD_BITS-1:0] clip_start_y_o,
  input wire logic [COORD_BITS-1:0] clip_start_z_o,
  input wire logic [COORD_BITS-1:0] clip_end_x_o,
  input wire logic [COORD_BITS-1:0] clip_end_y_o,
  input wire logic [COORD_BITS-1:0] clip_end_z_o
);

  // Input stalls only behind a stalled result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // Empty results carry zero coordinates
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (clip_start_x_o == '0 && clip_start_y_o == '0 &&
      clip_start_z_o == '0 && clip_end_x_o == '0 && clip_end_y_o == '0 &&
      clip_end_z_o == '0))
    else $error("empty result with nonzero coordinates");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(hit_o) &&
      $stable(clip_start_x_o) && $stable(clip_end_x_o)))
    else $error("stalled result changed");

  // A stalled input beat is not taken, and the result it waited behind stays valid
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && in_valid_i) |=> out_valid_o)
    else $error("result dropped while input stalled");

endmodule

bind segment_slab_clip ssc_chk #(.COORD_BITS(COORD_BITS)) u_ssc_chk (.*);

`default_nettype wire
